// ===== design/ide_pkg.sv =====
`timescale 1ns / 1ps

package ide_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int KIND_W = 4;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 4'd0,
      KIND_PUSH_FRONT = 4'd1,
      KIND_POP_BACK   = 4'd2,
      KIND_POP_FRONT  = 4'd3,
      KIND_READ_BACK  = 4'd4,
      KIND_READ_FRONT = 4'd5,
      KIND_READ_AT    = 4'd6,
      KIND_INSERT_AT  = 4'd7,
      KIND_REMOVE_AT  = 4'd8,
      KIND_CLEAR      = 4'd9
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_FETCH,
      S_GRAB,
      S_UP_CHK,
      S_UP_RD,
      S_UP_WR,
      S_DN_CHK,
      S_DN_RD,
      S_DN_WR,
      S_PUT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic cap;
      logic init_up;
      logic init_dn;
      logic rd_up;
      logic wr_up;
      logic rd_dn;
      logic wr_dn;
      logic fetch;
      logic grab;
      logic put;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic need_fetch;
      logic need_up;
      logic need_dn;
      logic need_put;
      logic up_done;
      logic dn_done;
   } stat_type;

endpackage

// ===== design/ide_ctrl.sv =====
`timescale 1ns / 1ps

module ide_ctrl
   import ide_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.need_fetch)    state_in = S_FETCH;
            else if (stat.need_up)  state_in = S_UP_CHK;
            else if (stat.need_put) state_in = S_PUT;
            else                    state_in = S_FINISH;
         end
         S_FETCH: state_in = S_GRAB;
         S_GRAB: begin
            state_in = stat.need_dn ? S_DN_CHK : S_FINISH;
         end
         S_UP_CHK: begin
            state_in = stat.up_done ? S_PUT : S_UP_RD;
         end
         S_UP_RD: state_in = S_UP_WR;
         S_UP_WR: state_in = S_UP_CHK;
         S_DN_CHK: begin
            state_in = stat.dn_done ? S_FINISH : S_DN_RD;
         end
         S_DN_RD: state_in = S_DN_WR;
         S_DN_WR: state_in = S_DN_CHK;
         S_PUT:   state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.cap    = req_tvalid;
         end
         S_DECIDE: cmd.init_up = stat.need_up && !stat.need_fetch;
         S_FETCH:  cmd.fetch   = 1'b1;
         S_GRAB: begin
            cmd.grab    = 1'b1;
            cmd.init_dn = stat.need_dn;
         end
         S_UP_RD:  cmd.rd_up = 1'b1;
         S_UP_WR:  cmd.wr_up = 1'b1;
         S_DN_RD:  cmd.rd_dn = 1'b1;
         S_DN_WR:  cmd.wr_dn = 1'b1;
         S_PUT:    cmd.put   = 1'b1;
         S_FINISH: cmd.load  = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/ide_datapath.sv =====
`timescale 1ns / 1ps

module ide_datapath
   import ide_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VAL_W-1:0]  req_value,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic signed [VAL_W-1:0]  rsp_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]         rsp_count
);

   // captured request
   kind_type                kind_ff, kind_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] grab_ff, grab_in;
   logic signed [VAL_W-1:0] rd_ff;

   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic signed [VAL_W-1:0] slot_mem [DEPTH];

   // decoded plan for the captured request
   logic                    p_fetch, p_up, p_dn, p_put, p_inc, p_dec, p_clear;
   logic [STAT_W-1:0]       p_status;
   logic signed [VAL_W-1:0] p_value;
   logic [ADDR_W-1:0]       tgt;

   logic                    empty, full, pos_ge, pos_gt;
   logic [CMP_W-1:0]        pos_cmp, cnt_cmp;
   logic [ADDR_W-1:0]       back_addr, raddr, waddr;
   logic                    wen;
   logic signed [VAL_W-1:0] wdata;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos_cmp   = CMP_W'(pos_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign pos_ge    = (pos_cmp >= cnt_cmp);
   assign pos_gt    = (pos_cmp > cnt_cmp);
   assign back_addr = ADDR_W'(count_ff - CNT_W'(1));

   always_comb begin
      p_fetch  = 1'b0;
      p_up     = 1'b0;
      p_dn     = 1'b0;
      p_put    = 1'b0;
      p_inc    = 1'b0;
      p_dec    = 1'b0;
      p_clear  = 1'b0;
      p_status = ST_OK;
      p_value  = '0;
      tgt      = '0;
      case (kind_ff)
         KIND_PUSH_BACK: begin
            if (full) begin
               p_status = ST_FULL;
            end else begin
               p_put = 1'b1;
               p_inc = 1'b1;
               tgt   = ADDR_W'(count_ff);
            end
         end
         KIND_PUSH_FRONT: begin
            if (full) begin
               p_status = ST_FULL;
            end else begin
               p_up  = 1'b1;
               p_put = 1'b1;
               p_inc = 1'b1;
            end
         end
         KIND_POP_BACK, KIND_READ_BACK: begin
            if (empty) begin
               p_status = ST_BAD;
               p_value  = -1;
            end else begin
               p_fetch = 1'b1;
               p_dec   = (kind_ff == KIND_POP_BACK);
               tgt     = back_addr;
            end
         end
         KIND_POP_FRONT, KIND_READ_FRONT: begin
            if (empty) begin
               p_status = ST_BAD;
               p_value  = -1;
            end else begin
               p_fetch = 1'b1;
               p_dn    = (kind_ff == KIND_POP_FRONT);
               p_dec   = (kind_ff == KIND_POP_FRONT);
            end
         end
         KIND_READ_AT, KIND_REMOVE_AT: begin
            if (pos_ge) begin
               p_status = ST_BAD;
               p_value  = -1;
            end else begin
               p_fetch = 1'b1;
               p_dn    = (kind_ff == KIND_REMOVE_AT);
               p_dec   = (kind_ff == KIND_REMOVE_AT);
               tgt     = ADDR_W'(pos_ff);
            end
         end
         KIND_INSERT_AT: begin
            // range check takes priority over the full check
            if (pos_gt) begin
               p_status = ST_BAD;
            end else if (full) begin
               p_status = ST_FULL;
            end else begin
               p_up  = 1'b1;
               p_put = 1'b1;
               p_inc = 1'b1;
               tgt   = ADDR_W'(pos_ff);
            end
         end
         KIND_CLEAR: p_clear = 1'b1;
         default: p_status = ST_OK;
      endcase
   end

   assign stat.need_fetch = p_fetch;
   assign stat.need_up    = p_up;
   assign stat.need_dn    = p_dn;
   assign stat.need_put   = p_put;
   assign stat.up_done    = (idx_ff == CNT_W'(tgt));
   assign stat.dn_done    = ((idx_ff + CNT_W'(1)) >= count_ff);

   always_comb begin
      kind_in = kind_ff;
      pos_in  = pos_ff;
      val_in  = val_ff;
      if (cmd.cap) begin
         kind_in = kind_type'(req_kind);
         pos_in  = req_position;
         val_in  = req_value;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.init_up)     idx_in = count_ff;
      else if (cmd.init_dn) idx_in = CNT_W'(tgt);
      else if (cmd.wr_up)  idx_in = idx_ff - CNT_W'(1);
      else if (cmd.wr_dn)  idx_in = idx_ff + CNT_W'(1);
   end

   assign grab_in = cmd.grab ? rd_ff : grab_ff;

   // one read and one write address per cycle
   always_comb begin
      raddr = '0;
      if (cmd.fetch)      raddr = tgt;
      else if (cmd.rd_up) raddr = ADDR_W'(idx_ff - CNT_W'(1));
      else if (cmd.rd_dn) raddr = ADDR_W'(idx_ff + CNT_W'(1));
   end

   assign wen   = cmd.wr_up || cmd.wr_dn || cmd.put;
   assign waddr = cmd.put ? tgt : ADDR_W'(idx_ff);
   assign wdata = cmd.put ? val_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (wen) slot_mem[waddr] <= wdata;
      rd_ff <= slot_mem[raddr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         if (p_clear)    count_in = '0;
         else if (p_inc) count_in = count_ff + CNT_W'(1);
         else if (p_dec) count_in = count_ff - CNT_W'(1);
      end
   end

   assign rsp_value_in  = p_fetch ? grab_ff : p_value;
   assign rsp_status_in = p_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      grab_ff <= grab_in;
      if (cmd.load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== design/indexed_deque_engine.sv =====
// steps: decode, shift entries up for a front push or insert, write or fetch the slot,
//   shift entries down for a front pop or remove, then load the output register
// throughput: one transaction at a time; the next is accepted the cycle after the
//   result is loaded into the output register
// reset: synchronous, active high; clears the entry count and handshake state,
//   slot contents are left as they are
`timescale 1ns / 1ps

module indexed_deque_engine
   import ide_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[6:0], value_in[38:7], zero[39]
   input  logic [3:0]  req_tuser,   // kind[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value_out[31:0], count[38:32], zero[39]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   cmd_type                 cmd;
   stat_type                stat;
   logic signed [VAL_W-1:0] rsp_value;
   logic [STAT_W-1:0]       rsp_status;
   logic [CNT_W-1:0]        rsp_count;

   ide_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ide_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_tuser),
      .req_position (req_tdata[6:0]),
      .req_value    (req_tdata[38:7]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

endmodule

// ===== design/ide_checker.sv =====
`timescale 1ns / 1ps

module ide_checker
   import ide_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // full status only when the store holds DEPTH entries
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[38:32] == 7'(DEPTH))
      else $error("full status with count below depth");

   // count never exceeds the store size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:32] <= 7'(DEPTH))
      else $error("count above depth");

   // one transaction at a time: ready drops after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

endmodule

bind indexed_deque_engine ide_checker u_ide_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
